// ===== sv/scfp_pkg.sv =====
package scfp_pkg;

    localparam int MAX_FRAME_BYTES_DEF     = 64;
    localparam int MAX_FRACTION_DIGITS_DEF = 6;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Quotient of the fraction scaling can reach 65536, so 17 bits.
    localparam int QUOT_BITS = 17;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } in_t;

    typedef struct packed {
        logic               accepted;
        logic [7:0]         command;
        logic               value_format;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } out_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SIGN = 3'd1,
        PH_INT  = 3'd2,
        PH_FRAC = 3'd3,
        PH_STOP = 3'd4
    } phase_t;

    typedef struct packed {
        logic step;
        logic div_start;
        logic div_step;
        logic finish;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic fin_pend;
        logic eof_fin;
        logic div_done;
        logic eof;
    } dp_status_t;

    function automatic logic [19:0] pow10(input logic [2:0] n);
        logic [19:0] r;
        case (n)
            3'd0:    r = 20'd1;
            3'd1:    r = 20'd10;
            3'd2:    r = 20'd100;
            3'd3:    r = 20'd1000;
            3'd4:    r = 20'd10000;
            3'd5:    r = 20'd100000;
            default: r = 20'd1000000;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/serial_command_frame_parser.sv =====
// Bytes are taken one at a time: in_ready is high only while idle, so no new byte
// is taken before the last is through. A byte that closes a number token starts the
// restoring divider that scales the fraction, then the value is saturated and stored,
// then the state is rechecked. The last byte of a frame (after scaling, saturation and
// storing if a token is still open) waits for a free output register, then loads it.
// Reset (rst_n low, asynchronous) clears all frame state and stored values.
module serial_command_frame_parser
    import scfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES     = MAX_FRAME_BYTES_DEF,
    parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    scfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    scfp_dp #(
        .MAX_FRAME_BYTES     (MAX_FRAME_BYTES),
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

// ===== sv/scfp_ctrl.sv =====
module scfp_ctrl
    import scfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_DIV,
        S_FIN,
        S_EOF
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (status.fin_pend)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (status.eof)
                    state_next = S_EOF;
                else
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_FIN;
                else
                    cmd.div_step = 1'b1;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_CHK;
            end
            S_EOF:
            begin
                if (status.eof_fin)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== sv/scfp_dp.sv =====
module scfp_dp
    import scfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES     = MAX_FRAME_BYTES_DEF,
    parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_t        in_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output out_t       out_data
);

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  first_reg, first_next;
    logic        colon_reg, colon_next;
    logic [1:0]  field_reg, field_next;
    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [15:0] int_reg, int_next;
    logic [19:0] frac_reg, frac_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] held0_reg, held0_next;
    logic [31:0] held1_reg, held1_next;
    logic [31:0] vals_reg [3];
    logic [31:0] vals_next [3];
    logic        eof_reg, eof_next;
    logic        pend_reg, pend_next;
    logic [19:0] rem_reg, rem_next;
    logic [16:0] nlow_reg, nlow_next;
    logic [16:0] quot_reg, quot_next;
    logic [19:0] divisor_reg, divisor_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    out_t        out_reg, out_next;

    logic [7:0]  c;
    logic [3:0]  dval;
    logic        upper, lower, accepted;
    logic        is_digit, is_sign, is_num;
    logic [3:0]  k;
    logic [31:0] asm_tmp;
    logic [19:0] int_t;
    logic [36:0] numer;
    logic [19:0] dv;
    logic [20:0] r2;
    logic [32:0] mag;
    logic [31:0] tok_val;

    assign c        = in_data.data_byte;
    assign dval     = 4'(c - CH_ZERO);
    assign upper    = (first_reg >= CH_UP_A) && (first_reg <= CH_UP_Z);
    assign lower    = (first_reg >= CH_LO_A) && (first_reg <= CH_LO_Z);
    assign accepted = (pos_reg >= 8'd2) && colon_reg;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign is_num   = is_digit || is_sign || (c == CH_POINT);
    assign k        = 4'(pos_reg - 8'd2);

    always_comb
    begin
        pos_next     = pos_reg;
        first_next   = first_reg;
        colon_next   = colon_reg;
        field_next   = field_reg;
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        int_next     = int_reg;
        frac_next    = frac_reg;
        fcnt_next    = fcnt_reg;
        asm_next     = asm_reg;
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        vals_next    = vals_reg;
        eof_next     = eof_reg;
        pend_next    = pend_reg;
        rem_next     = rem_reg;
        nlow_next    = nlow_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        dcnt_next    = dcnt_reg;
        out_next     = out_reg;
        asm_tmp      = '0;
        int_t        = '0;
        numer        = '0;
        dv           = '0;
        r2           = '0;
        mag          = '0;
        tok_val      = '0;

        if (cmd.step)
        begin
            eof_next = in_data.end_of_frame;
            if (pos_reg < 8'(MAX_FRAME_BYTES))
            begin
                pos_next = pos_reg + 8'd1;
                if (pos_reg == 8'd0)
                    first_next = c;
                else if (pos_reg == 8'd1)
                    colon_next = (c == CH_COLON);
                else if (colon_reg && upper)
                begin
                    if (pos_reg <= 8'd13)
                    begin
                        asm_tmp  = (k[1:0] == 2'd0) ? 32'd0 : asm_reg;
                        asm_tmp  = asm_tmp | (32'(c) << {k[1:0], 3'b000});
                        asm_next = asm_tmp;
                        if (k[1:0] == 2'd3 && k[3:2] == 2'd0)
                            held0_next = asm_tmp;
                        if (k[1:0] == 2'd3 && k[3:2] == 2'd1)
                            held1_next = asm_tmp;
                    end
                end
                else if (colon_reg && lower)
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (is_num && field_reg != 2'd3)
                        begin
                            neg_next  = 1'b0;
                            int_next  = '0;
                            frac_next = '0;
                            fcnt_next = '0;
                            if (is_sign)
                            begin
                                neg_next   = (c == CH_MINUS);
                                phase_next = PH_SIGN;
                            end
                            else if (is_digit)
                            begin
                                int_next   = 16'(dval);
                                phase_next = PH_INT;
                            end
                            else
                                phase_next = PH_FRAC;
                        end
                    end
                    else if (!is_num)
                        pend_next = 1'b1;
                    else if (phase_reg != PH_STOP)
                    begin
                        if (is_digit)
                        begin
                            if (phase_reg == PH_FRAC)
                            begin
                                if (fcnt_reg < 3'(MAX_FRACTION_DIGITS))
                                begin
                                    frac_next = 20'(frac_reg * 20'd10) + 20'(dval);
                                    fcnt_next = fcnt_reg + 3'd1;
                                end
                            end
                            else
                            begin
                                int_t      = 20'(int_reg) * 20'd10 + 20'(dval);
                                int_next   = (int_t > 20'hFFFF) ? 16'hFFFF : int_t[15:0];
                                phase_next = PH_INT;
                            end
                        end
                        else if (c == CH_POINT && phase_reg != PH_FRAC)
                            phase_next = PH_FRAC;
                        else
                            phase_next = PH_STOP;
                    end
                end
            end
        end

        // Fraction scaling: round(F * 65536 / 10^n) by restoring division,
        // one quotient bit per cycle.
        if (cmd.div_start)
        begin
            dv           = pow10(fcnt_reg);
            numer        = {1'b0, frac_reg, 16'd0} + 37'(dv >> 1);
            divisor_next = dv;
            rem_next     = numer[36:17];
            nlow_next    = numer[16:0];
            quot_next    = '0;
            dcnt_next    = 5'(QUOT_BITS);
        end

        if (cmd.div_step)
        begin
            r2 = {rem_reg, nlow_reg[16]};
            if (r2 >= {1'b0, divisor_reg})
            begin
                rem_next  = 20'(r2 - {1'b0, divisor_reg});
                quot_next = {quot_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next  = r2[19:0];
                quot_next = {quot_reg[15:0], 1'b0};
            end
            nlow_next = {nlow_reg[15:0], 1'b0};
            dcnt_next = dcnt_reg - 5'd1;
        end

        if (cmd.finish)
        begin
            mag = {1'b0, int_reg, 16'd0} + 33'(quot_reg);
            if (neg_reg)
                tok_val = (mag >= 33'h080000000) ? 32'h80000000 : 32'(33'd0 - mag);
            else
                tok_val = (mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
            if (field_reg != 2'd3)
            begin
                vals_next[field_reg] = tok_val;
                field_next           = field_reg + 2'd1;
            end
            phase_next = PH_IDLE;
            neg_next   = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            fcnt_next  = '0;
            pend_next  = 1'b0;
        end

        if (cmd.emit)
        begin
            out_next.accepted     = accepted;
            out_next.command      = '0;
            out_next.value_format = 1'b0;
            if (accepted && upper)
            begin
                out_next.value_format = 1'b1;
                if (pos_reg >= 8'd14)
                begin
                    vals_next[0]     = held0_reg;
                    vals_next[1]     = held1_reg;
                    vals_next[2]     = asm_reg;
                    out_next.command = first_reg;
                end
            end
            else if (accepted && lower && field_reg == 2'd3)
                out_next.command = first_reg;
            out_next.value_x = vals_next[0];
            out_next.value_y = vals_next[1];
            out_next.value_z = vals_next[2];

            pos_next   = '0;
            first_next = '0;
            colon_next = 1'b0;
            field_next = '0;
            phase_next = PH_IDLE;
            neg_next   = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            fcnt_next  = '0;
            asm_next   = '0;
            held0_next = '0;
            held1_next = '0;
            pend_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            first_reg   <= '0;
            colon_reg   <= 1'b0;
            field_reg   <= '0;
            phase_reg   <= PH_IDLE;
            neg_reg     <= 1'b0;
            int_reg     <= '0;
            frac_reg    <= '0;
            fcnt_reg    <= '0;
            asm_reg     <= '0;
            held0_reg   <= '0;
            held1_reg   <= '0;
            vals_reg[0] <= '0;
            vals_reg[1] <= '0;
            vals_reg[2] <= '0;
            eof_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            dcnt_reg    <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
            colon_reg <= colon_next;
            field_reg <= field_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            fcnt_reg  <= fcnt_next;
            asm_reg   <= asm_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            vals_reg  <= vals_next;
            eof_reg   <= eof_next;
            pend_reg  <= pend_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        nlow_reg    <= nlow_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
        out_reg     <= out_next;
    end

    assign status.fin_pend = pend_reg;
    assign status.eof_fin  = accepted && lower && (phase_reg != PH_IDLE);
    assign status.div_done = (dcnt_reg == 5'd0);
    assign status.eof      = eof_reg;
    assign out_data        = out_reg;

endmodule

// ===== sv/scfp_checker.sv =====
module scfp_checker
    import scfp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed before it was taken");

    a_busy_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("byte accepted on two consecutive cycles");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.accepted |->
            out_data.command == 8'd0 && !out_data.value_format)
        else $error("rejected frame reports a command or format");

    a_cmd_letter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.command != 8'd0 |->
            out_data.value_format == (out_data.command <= CH_UP_Z))
        else $error("command letter case does not match value format");

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
